// ===== hdl/spiq_pkg.sv =====
// ----------------------------------------------------------------------------
// spiq_pkg
// Types and codes shared by the sorted priority insert queue modules.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_LIST   = 1'b1;

  localparam logic [1:0] KIND_INSERTED   = 2'd0;
  localparam logic [1:0] KIND_REJECTED   = 2'd1;
  localparam logic [1:0] KIND_LIST_ENTRY = 2'd2;
  localparam logic [1:0] KIND_LIST_EMPTY = 2'd3;

  localparam logic [7:0] ADULT_AGE_RESET = 8'd18;

  typedef struct packed {
    logic       mode;
    logic       is_female;
    logic       is_wealthy;
    logic [7:0] age;
    logic [7:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] entry_tag;
    logic [2:0] entry_priority;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [2:0] prio;
  } slot_t;

  typedef struct packed {
    logic  insert;
    logic  rotate;
    slot_t item;
  } cell_ctrl_t;

endpackage

// ===== hdl/spiq_cell.sv =====
// ----------------------------------------------------------------------------
// spiq_cell
// One queue slot: holds, takes the new entry, shifts from the slot ahead on
// insert, or takes the slot behind during a list rotation.
// ----------------------------------------------------------------------------
module spiq_cell (
  input  logic               clk_i,
  input  spiq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               prev_keep_i,
  input  spiq_pkg::slot_t    prev_i,
  input  spiq_pkg::slot_t    next_i,
  output logic               keep_o,
  output spiq_pkg::slot_t    slot_o
);

  spiq_pkg::slot_t slot_q, slot_d;

  assign keep_o = occ_i && (slot_q.prio > ctrl_i.item.prio);
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.rotate) begin
      slot_d = next_i;
    end else if (ctrl_i.insert && !keep_o) begin
      slot_d = prev_keep_i ? ctrl_i.item : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ===== hdl/sorted_priority_insert_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_insert_queue_top
// Bounded queue kept in descending priority order in a chain of slot cells.
// ----------------------------------------------------------------------------
// On an insert every cell compares its priority with the new one at once and
// the chain shifts by one place behind the insertion point, so inserts and
// rejects can be accepted back to back while the output is not stalled. A
// list request rotates the chain one place per cycle unless a pending entry
// waits on a stalled output; the head cell feeds the output while occupied
// entries remain, and the rotation finishes the full circle to restore the
// order; no input is accepted meanwhile. A list of an empty queue gives a list-empty result.
module sorted_priority_insert_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spiq_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spiq_pkg::out_item_t  out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic                state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [7:0]          adult_age_q;
  logic                out_valid_q, out_valid_d;
  spiq_pkg::out_item_t out_q, out_d;

  logic                out_free, in_fire, full, ins, step, pending, emit;
  logic [CntW-1:0]     idx_ext;
  logic [2:0]          new_prio;
  spiq_pkg::cell_ctrl_t ctrl;
  spiq_pkg::slot_t     slot [DEPTH];
  logic                keep [DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign new_prio   = {2'b00, in_data_i.is_wealthy}
                    + ((in_data_i.age < adult_age_q) ? 3'd2 : 3'd0)
                    + {2'b00, in_data_i.is_female};
  assign ins        = in_fire && (in_data_i.mode == spiq_pkg::MODE_INSERT) && !full;

  assign idx_ext = CntW'(idx_q);
  assign pending = idx_ext < count_q;
  assign step    = (state_q == ST_LIST) && (!pending || out_free);
  assign emit    = step && pending;

  assign ctrl.insert    = ins;
  assign ctrl.rotate    = step;
  assign ctrl.item.tag  = in_data_i.tag;
  assign ctrl.item.prio = new_prio;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spiq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (CntW'(i) < count_q),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i + DEPTH - 1) % DEPTH]),
      .prev_i      (slot[(i + DEPTH - 1) % DEPTH]),
      .next_i      (slot[(i + 1) % DEPTH]),
      .keep_o      (keep[i]),
      .slot_o      (slot[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d         = 1'b1;
      out_d.last          = 1'b1;
      out_d.entry_tag     = in_data_i.tag;
      out_d.entry_priority = new_prio;
      if (in_data_i.mode == spiq_pkg::MODE_INSERT) begin
        out_d.result_kind = full ? spiq_pkg::KIND_REJECTED : spiq_pkg::KIND_INSERTED;
        if (!full) begin
          count_d = count_q + CntW'(1);
        end
      end else if (count_q == '0) begin
        out_d.result_kind    = spiq_pkg::KIND_LIST_EMPTY;
        out_d.entry_tag      = 8'd0;
        out_d.entry_priority = 3'd0;
      end else begin
        out_valid_d = out_valid_q && !out_ready_i;
        state_d     = ST_LIST;
        idx_d       = '0;
      end
    end
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d.result_kind    = spiq_pkg::KIND_LIST_ENTRY;
      out_d.entry_tag      = slot[0].tag;
      out_d.entry_priority = slot[0].prio;
      out_d.last           = (idx_ext == count_q - CntW'(1));
    end
    if (step) begin
      if (idx_q == IdxW'(DEPTH - 1)) begin
        state_d = ST_IDLE;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      adult_age_q <= spiq_pkg::ADULT_AGE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        adult_age_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/tb_sorted_priority_insert_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_insert_queue_top
// Self-checking bench for the sorted priority insert queue. A directed table
// fills the queue through every priority level, ties, the empty list and the
// full-queue reject. Random phases then follow, each under its own adult age.
// Every accepted request runs through a local roster model. Each result
// transfer is checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_sorted_priority_insert_queue_top;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 64;

  typedef struct {
    spiq_pkg::in_item_t  item;
    bit                  typed;
    spiq_pkg::out_item_t res;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [7:0]          cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  spiq_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  spiq_pkg::out_item_t out_data_o;

  spiq_pkg::slot_t     roster_q[$];
  spiq_pkg::out_item_t pending_q[$];
  stim_row_t           dir_rows[$];
  logic [7:0]          adult_age_q = spiq_pkg::ADULT_AGE_RESET;
  bit                  row_typed   = 1'b0;
  spiq_pkg::out_item_t row_res     = '0;
  int                  mismatches  = 0;
  int                  burst_left  = 0;
  int                  stall_mode  = 0;
  int                  stall_cnt   = 0;

  sorted_priority_insert_queue_top #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic spiq_pkg::out_item_t mk_result(logic [1:0] kind, logic [7:0] tag,
                                                    logic [2:0] prio, logic last);
    spiq_pkg::out_item_t r;
    r.result_kind    = kind;
    r.entry_tag      = tag;
    r.entry_priority = prio;
    r.last           = last;
    return r;
  endfunction

  function automatic logic [2:0] passenger_prio(logic female, logic wealthy,
                                                logic [7:0] age);
    logic [2:0] p;
    p = {2'b00, wealthy} + {2'b00, female};
    if (age < adult_age_q) p = p + 3'd2;
    return p;
  endfunction

  task automatic predict_roster(input spiq_pkg::in_item_t it);
    logic [2:0]      p;
    int              pos;
    spiq_pkg::slot_t s;
    pos = 0;
    if (it.mode == spiq_pkg::MODE_INSERT) begin
      p = passenger_prio(it.is_female, it.is_wealthy, it.age);
      if (roster_q.size() >= QDEPTH) begin
        pending_q.push_back(mk_result(spiq_pkg::KIND_REJECTED, it.tag, p, 1'b1));
      end else begin
        while (pos < roster_q.size() && roster_q[pos].prio > p) pos++;
        s.tag  = it.tag;
        s.prio = p;
        roster_q.insert(pos, s);
        pending_q.push_back(mk_result(spiq_pkg::KIND_INSERTED, it.tag, p, 1'b1));
      end
    end else if (roster_q.size() == 0) begin
      pending_q.push_back(mk_result(spiq_pkg::KIND_LIST_EMPTY, 8'd0, 3'd0, 1'b1));
    end else begin
      foreach (roster_q[i])
        pending_q.push_back(mk_result(spiq_pkg::KIND_LIST_ENTRY, roster_q[i].tag,
                                      roster_q[i].prio, i == roster_q.size() - 1));
    end
  endtask

  task automatic note_failure(input string what, input spiq_pkg::out_item_t ex,
                              input spiq_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: exp kind=%0d tag=%02h prio=%0d last=%0b",
                " got kind=%0d tag=%02h prio=%0d last=%0b"},
               what, ex.result_kind, ex.entry_tag, ex.entry_priority, ex.last,
               got.result_kind, got.entry_tag, got.entry_priority, got.last);
  endtask

  always @(posedge clk_i) begin
    spiq_pkg::out_item_t ex;
    if (rst_ni) begin
      if (cfg_we_i) adult_age_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        predict_roster(in_data_i);
        if (row_typed) begin
          void'(pending_q.pop_back());
          pending_q.push_back(row_res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          note_failure("unexpected result", '0, out_data_o);
        end else begin
          ex = pending_q.pop_front();
          if (out_data_o.result_kind !== ex.result_kind ||
              out_data_o.entry_tag !== ex.entry_tag ||
              out_data_o.entry_priority !== ex.entry_priority ||
              out_data_o.last !== ex.last)
            note_failure("mismatch", ex, out_data_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 40 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= (stall_cnt % 5 != 4);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  task automatic transfer(input spiq_pkg::in_item_t it, input bit typed,
                          input spiq_pkg::out_item_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = it;
    row_typed  = typed;
    row_res    = res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    row_typed  = 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (2 * QDEPTH + 4) @(negedge clk_i);
  endtask

  task automatic add_row(input logic mode, input logic f, input logic w,
                         input logic [7:0] age, input logic [7:0] tag,
                         input bit typed, input spiq_pkg::out_item_t res);
    stim_row_t r;
    r.item.mode       = mode;
    r.item.is_female  = f;
    r.item.is_wealthy = w;
    r.item.age        = age;
    r.item.tag        = tag;
    r.typed           = typed;
    r.res             = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    int                 phase_ages[5];
    logic [7:0]         pa;
    spiq_pkg::in_item_t it;

    add_row(spiq_pkg::MODE_LIST,   1'b0, 1'b0, 8'h00, 8'h00, 1'b1,
            mk_result(spiq_pkg::KIND_LIST_EMPTY, 8'h00, 3'd0, 1'b1));
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b1, 8'd0,   8'hFF, 1'b1,
            mk_result(spiq_pkg::KIND_INSERTED, 8'hFF, 3'd4, 1'b1));
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd255, 8'h00, 1'b1,
            mk_result(spiq_pkg::KIND_INSERTED, 8'h00, 3'd0, 1'b1));
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b0, 8'd18,  8'h11, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd17,  8'h22, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b1, 8'd30,  8'h33, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b1, 8'd17,  8'h44, 1'b0, '0);
    add_row(spiq_pkg::MODE_LIST,   1'b1, 1'b0, 8'hA5, 8'h5A, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd0,   8'h55, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b0, 8'd5,   8'hAA, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b1, 8'd200, 8'h5A, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b1, 8'd18,  8'hA5, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd254, 8'h0F, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b0, 8'd16,  8'hF0, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b1, 8'd1,   8'h3C, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b1, 8'd254, 8'hC3, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd18,  8'h81, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b0, 8'd0,   8'h7E, 1'b0, '0);
    add_row(spiq_pkg::MODE_INSERT, 1'b1, 1'b1, 8'd0,   8'h99, 1'b1,
            mk_result(spiq_pkg::KIND_REJECTED, 8'h99, 3'd4, 1'b1));
    add_row(spiq_pkg::MODE_INSERT, 1'b0, 1'b0, 8'd255, 8'h00, 1'b1,
            mk_result(spiq_pkg::KIND_REJECTED, 8'h00, 3'd0, 1'b1));
    add_row(spiq_pkg::MODE_LIST,   1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0, '0);

    phase_ages[0] = 0;
    phase_ages[1] = 255;
    phase_ages[2] = $urandom_range(1, 254);
    phase_ages[3] = $urandom_range(1, 254);
    phase_ages[4] = 18;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) transfer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    foreach (phase_ages[p]) begin
      pa          = 8'(phase_ages[p]);
      cfg_we_i    = 1'b1;
      cfg_wdata_i = pa;
      @(negedge clk_i);
      cfg_we_i    = 1'b0;
      repeat (PHASE_ITEMS) begin
        it.mode       = ($urandom_range(0, 99) < 30) ? spiq_pkg::MODE_LIST
                                                     : spiq_pkg::MODE_INSERT;
        it.is_female  = 1'($urandom_range(0, 1));
        it.is_wealthy = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: it.age = pa;
          1: it.age = pa - 8'd1;
          default: it.age = 8'($urandom_range(0, 255));
        endcase
        it.tag = 8'($urandom_range(0, 255));
        transfer(it, 1'b0, '0);
      end
      drain_results();
    end

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
